@@ hdl/qsps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Quicksort pivot select package
// Beat payload types and shared constants.
// ----------------------------------------------------------------------------
package qsps_pkg;

	localparam logic [15:0] LFSR_MASK = 16'hB400;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	localparam logic [1:0] PIV_FIRST  = 2'd0;
	localparam logic [1:0] PIV_RANDOM = 2'd1;
	localparam logic [1:0] PIV_MIDDLE = 2'd2;
	localparam logic [1:0] PIV_MEDIAN = 2'd3;

	localparam logic REG_PIVOT_MODE = 1'b0;
	localparam logic REG_SEED       = 1'b1;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               end_of_run;
		logic [15:0]        comparison_count;
	} out_beat_t;

endpackage
`default_nettype wire

@@ hdl/quicksort_pivot_select.sv @@
`default_nettype none
// Timing: one beat loads per cycle while in_ready is high; after the last
//   beat the sort runs on one memory port: a read per compare, two reads and
//   two writes per swap, a pop, pivot read and push per range, and for a
//   median pivot three reads more, for a random pivot a modulo reduction.
// Throughput: one data set at a time; in_ready is low during sort and drain.
// Reset: control, count, mode and LFSR clear to reset values; store undefined.
// ----------------------------------------------------------------------------
// Quicksort pivot select
// Iterative in-place quicksort over a single-port element memory.
// ----------------------------------------------------------------------------
module quicksort_pivot_select #(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire qsps_pkg::in_beat_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output qsps_pkg::out_beat_t     out_data,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	localparam int unsigned IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam logic [IW:0] MAXN = (IW+1)'(MAX_ELEMENTS);

	// what follows a swap
	localparam logic [1:0] NX_PIVOT = 2'd0;
	localparam logic [1:0] NX_SCAN  = 2'd1;
	localparam logic [1:0] NX_PUSH  = 2'd3;

	typedef enum logic [15:0] {
		S_LOAD  = 16'b0000_0000_0000_0001,
		S_POP   = 16'b0000_0000_0000_0010,
		S_PIV   = 16'b0000_0000_0000_0100,
		S_MOD   = 16'b0000_0000_0000_1000,
		S_RDA   = 16'b0000_0000_0001_0000,
		S_RDB   = 16'b0000_0000_0010_0000,
		S_RDC   = 16'b0000_0000_0100_0000,
		S_SWPA  = 16'b0000_0000_1000_0000,
		S_SWPB  = 16'b0000_0001_0000_0000,
		S_PVRD  = 16'b0000_0010_0000_0000,
		S_SCI   = 16'b0000_0100_0000_0000,
		S_SCJ   = 16'b0000_1000_0000_0000,
		S_XCH   = 16'b0001_0000_0000_0000,
		S_PUSH  = 16'b0010_0000_0000_0000,
		S_OUTRD = 16'b0100_0000_0000_0000,
		S_OUT   = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;

	logic signed [31:0] mem [MAX_ELEMENTS];
	logic signed [31:0] rd_q;
	logic               we;
	logic [IW-1:0]      waddr, raddr;
	logic signed [31:0] wdata;

	logic [1:0]   mode_q;
	logic [15:0]  lfsr_q;
	logic [15:0]  cmp_q;
	logic [IW:0]  cnt_q;
	logic [2*IW-1:0] stk [MAX_ELEMENTS];
	logic [2*IW-1:0] stk_rd_q;
	logic [IW:0]  sp_q;
	logic [IW-1:0] lo_q, hi_q, i_q, j_q, a_q, b_q, k_q;
	logic         iovf_q;
	logic signed [31:0] va_q, vb_q, piv_q;
	logic [1:0]   sub_q;
	logic         xph_q;
	logic [IW-1:0] mid;
	logic [IW:0]  sum;
	logic         md_start, md_done;
	logic [IW:0]  md_rem;
	logic [15:0]  lfsr_nx;
	logic signed [31:0] med;
	logic [IW-1:0] last_hi;
	logic         push_r, push_l;
	logic         k_last;

	assign sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = sum[IW:1];
	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ qsps_pkg::LFSR_MASK) : (lfsr_q >> 1);
	assign last_hi = (cnt_q < MAXN) ? cnt_q[IW-1:0] : IW'(MAX_ELEMENTS - 1);
	assign push_r = ({1'b0, j_q} + (IW+1)'(1)) < {1'b0, hi_q};
	assign push_l = ({1'b0, lo_q} + (IW+1)'(1)) < {1'b0, j_q};
	assign k_last = ({1'b0, k_q} + (IW+1)'(1)) == cnt_q;

	// median of low, middle and high; high value is on the read port
	always_comb begin
		if ((va_q > vb_q) != (va_q > rd_q))
			med = va_q;
		else if ((vb_q > va_q) != (vb_q > rd_q))
			med = vb_q;
		else
			med = rd_q;
	end

	qsps_modred #(.IW(IW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(md_start), .dividend(lfsr_nx),
		.divisor({1'b0, hi_q} - {1'b0, lo_q} + (IW+1)'(1)),
		.done(md_done), .remainder(md_rem)
	);

	assign in_ready = (state_q == S_LOAD);
	assign md_start = (state_q == S_PIV) && (mode_q == qsps_pkg::PIV_RANDOM);

	// memory port control
	always_comb begin
		we = 1'b0; waddr = '0; wdata = in_data.value; raddr = '0;
		unique case (state_q)
			S_LOAD: begin
				we = in_valid && (cnt_q < MAXN);
				waddr = cnt_q[IW-1:0];
			end
			S_RDA:   raddr = lo_q;
			S_RDB:   raddr = mid;
			S_RDC:   raddr = hi_q;
			S_SWPA:  raddr = a_q;
			S_SWPB:  raddr = b_q;
			S_PVRD:  raddr = lo_q;
			S_SCI:   raddr = i_q;
			S_SCJ:   raddr = j_q;
			S_XCH: begin
				we = 1'b1; waddr = xph_q ? b_q : a_q; wdata = xph_q ? va_q : vb_q;
			end
			S_OUTRD: raddr = k_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// range stack: right range pushed first so the left is popped first
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && in_valid && in_data.last) begin
			stk[0] <= {IW'(0), last_hi};
		end else if (state_q == S_PUSH) begin
			if (push_r) begin
				stk[sp_q[IW-1:0]] <= {j_q + IW'(1), hi_q};
				if (push_l)
					stk[sp_q[IW-1:0] + IW'(1)] <= {lo_q, j_q - IW'(1)};
			end else if (push_l) begin
				stk[sp_q[IW-1:0]] <= {lo_q, j_q - IW'(1)};
			end
		end
		stk_rd_q <= stk[sp_q[IW-1:0] - IW'(1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= qsps_pkg::PIV_FIRST;
			lfsr_q <= 16'd1;
		end else if (cfg_we) begin
			if (cfg_index == qsps_pkg::REG_PIVOT_MODE)
				mode_q <= cfg_data[1:0];
			else
				lfsr_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
		end else if (state_q == S_PIV && mode_q == qsps_pkg::PIV_RANDOM) begin
			lfsr_q <= lfsr_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cmp_q <= '0;
			cnt_q <= '0;
			sp_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
			sub_q <= '0;
			xph_q <= 1'b0;
			iovf_q <= 1'b0;
			lo_q <= '0; hi_q <= '0; i_q <= '0; j_q <= '0;
			a_q <= '0; b_q <= '0; k_q <= '0;
			va_q <= '0; vb_q <= '0; piv_q <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: if (in_valid) begin
					if (cnt_q < MAXN)
						cnt_q <= cnt_q + (IW+1)'(1);
					if (in_data.last) begin
						cmp_q <= '0;
						k_q <= '0;
						if (cnt_q != '0) begin
							sp_q <= (IW+1)'(1);
							state_q <= S_POP;
						end else begin
							sp_q <= '0;
							state_q <= S_OUTRD;
						end
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_OUTRD;
					end else if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else begin
						lo_q <= stk_rd_q[2*IW-1:IW];
						hi_q <= stk_rd_q[IW-1:0];
						sp_q <= sp_q - (IW+1)'(1);
						sub_q <= 2'd0;
						state_q <= S_PIV;
					end
				end
				S_PIV: begin
					a_q <= lo_q;
					unique case (mode_q)
						qsps_pkg::PIV_RANDOM: state_q <= S_MOD;
						qsps_pkg::PIV_MIDDLE: begin
							b_q <= mid; state_q <= S_SWPA;
						end
						qsps_pkg::PIV_MEDIAN: state_q <= S_RDA;
						default: state_q <= S_PVRD;
					endcase
				end
				S_MOD: if (md_done) begin
					b_q <= lo_q + md_rem[IW-1:0];
					state_q <= S_SWPA;
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin va_q <= rd_q; state_q <= S_RDC; end
				S_RDC: begin
					if (sub_q == 2'd0) begin
						vb_q <= rd_q;
						sub_q <= 2'd1;
					end else begin
						sub_q <= 2'd0;
						if (med == vb_q) begin
							b_q <= mid; state_q <= S_SWPA;
						end else if (med == rd_q) begin
							b_q <= hi_q; state_q <= S_SWPA;
						end else
							state_q <= S_PVRD;
					end
				end
				S_SWPA: begin
					xph_q <= 1'b0;
					state_q <= S_SWPB;
				end
				S_SWPB: begin
					if (!xph_q) begin
						va_q <= rd_q; xph_q <= 1'b1;
					end else begin
						xph_q <= 1'b0;
						vb_q <= rd_q;
						state_q <= S_XCH;
					end
				end
				S_XCH: begin
					if (!xph_q) begin
						xph_q <= 1'b1;
					end else begin
						xph_q <= 1'b0;
						sub_q <= 2'd0;
						case (sub_q)
							NX_PIVOT: state_q <= S_PVRD;
							NX_SCAN:  state_q <= S_SCI;
							default:  state_q <= S_PUSH;
						endcase
					end
				end
				S_PVRD: begin
					if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else begin
						piv_q <= rd_q;
						i_q <= lo_q + IW'(1);
						iovf_q <= (lo_q == hi_q);
						j_q <= hi_q;
						sub_q <= 2'd0;
						state_q <= S_SCI;
					end
				end
				S_SCI: begin
					if (iovf_q || i_q > hi_q) begin
						sub_q <= 2'd0; state_q <= S_SCJ;
					end else if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else begin
						sub_q <= 2'd0;
						if (rd_q <= piv_q) begin
							if (cmp_q != qsps_pkg::COUNT_MAX) cmp_q <= cmp_q + 16'd1;
							if (i_q == IW'(MAX_ELEMENTS - 1)) iovf_q <= 1'b1;
							else i_q <= i_q + IW'(1);
						end else
							state_q <= S_SCJ;
					end
				end
				S_SCJ: begin
					if (j_q <= lo_q || (sub_q == 2'd1 && !(rd_q > piv_q))) begin
						state_q <= S_SWPA;
						b_q <= j_q;
						if (iovf_q || i_q >= j_q) begin
							a_q <= lo_q; sub_q <= NX_PUSH;
						end else begin
							a_q <= i_q; sub_q <= NX_SCAN;
						end
					end else if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else begin
						sub_q <= 2'd0;
						if (cmp_q != qsps_pkg::COUNT_MAX) cmp_q <= cmp_q + 16'd1;
						j_q <= j_q - IW'(1);
					end
				end
				S_PUSH: begin
					sp_q <= sp_q + (IW+1)'(push_r) + (IW+1)'(push_l);
					state_q <= S_POP;
				end
				S_OUTRD: begin
					if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else begin
						sub_q <= 2'd0;
						out_valid <= 1'b1;
						out_data.sorted_value <= rd_q;
						out_data.end_of_run <= k_last;
						out_data.comparison_count <= k_last ? cmp_q : 16'd0;
						state_q <= S_OUT;
					end
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					if (k_last) begin
						cnt_q <= '0; cmp_q <= '0; state_q <= S_LOAD;
					end else begin
						k_q <= k_q + IW'(1); state_q <= S_OUTRD;
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("beat outside drain");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("load overlaps drain");
	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= MAXN) else $error("range stack overflow");

endmodule
`default_nettype wire

@@ hdl/qsps_modred.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Quicksort pivot select modulo reducer
// Restoring remainder of a 16-bit value by a small size, one bit a cycle.
// ----------------------------------------------------------------------------
module qsps_modred #(
	parameter int unsigned IW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [15:0]   dividend,
	input  wire logic [IW:0]   divisor,
	output logic               done,
	output logic [IW:0]        remainder
);

	logic [15:0]  dvd_q;
	logic [IW:0]  dvs_q;
	logic [IW:0]  rem_q;
	logic [4:0]   cnt_q;
	logic         busy_q;
	logic [IW+1:0] trial;

	assign trial = {rem_q, dvd_q[15]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			if (!trial[IW+1])
				rem_q <= trial[IW:0];
			else
				rem_q <= {rem_q[IW-1:0], dvd_q[15]};
		end
	end

	assign remainder = rem_q;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quicksort pivot select testbench
// Streams data sets through the sorter under each pivot mode and several
// seeds, predicts sorted output and comparison count, and checks every beat.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAXN = 64;
	localparam int WDOG = 200000;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	qsps_pkg::in_beat_t in_data;
	qsps_pkg::out_beat_t out_data;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;

	quicksort_pivot_select dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	qsps_pkg::in_beat_t pending_beats[$];
	qsps_pkg::out_beat_t sorted_expect[$];
	int errors;
	int wdog_cnt;
	bit quiet;
	bit in_fire;
	int in_gap, out_gap;

	logic [1:0] mode_m;
	logic [15:0] lfsr_m;
	logic signed [31:0] store_m[MAXN];
	int count_m;
	int cmp_m;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic void swap_el(int a, int b);
		logic signed [31:0] t;
		t = store_m[a]; store_m[a] = store_m[b]; store_m[b] = t;
	endfunction

	function automatic void bump();
		if (cmp_m < 65535) cmp_m++;
	endfunction

	function automatic void pick_pivot(int lo, int hi);
		int mid;
		logic signed [31:0] a, b, c, m;
		mid = (lo + hi) / 2;
		case (mode_m)
			qsps_pkg::PIV_RANDOM: begin
				lfsr_m = lfsr_m[0] ? ((lfsr_m >> 1) ^ qsps_pkg::LFSR_MASK) : (lfsr_m >> 1);
				swap_el(lo, lo + int'(lfsr_m) % (hi - lo + 1));
			end
			qsps_pkg::PIV_MIDDLE: swap_el(lo, mid);
			qsps_pkg::PIV_MEDIAN: begin
				a = store_m[lo]; b = store_m[mid]; c = store_m[hi];
				if ((a > b) != (a > c)) m = a;
				else if ((b > a) != (b > c)) m = b;
				else m = c;
				if (m == store_m[mid]) swap_el(lo, mid);
				else if (m == store_m[hi]) swap_el(lo, hi);
			end
			default: ;
		endcase
	endfunction

	function automatic void sort_and_expect();
		int lo_q[$], hi_q[$];
		int lo, hi, i, j;
		logic signed [31:0] pv;
		qsps_pkg::out_beat_t o;
		cmp_m = 0;
		if (count_m > 1) begin
			lo_q.push_back(0); hi_q.push_back(count_m - 1);
		end
		while (lo_q.size() > 0) begin
			lo = lo_q.pop_back(); hi = hi_q.pop_back();
			pick_pivot(lo, hi);
			pv = store_m[lo];
			i = lo + 1; j = hi;
			forever begin
				while (i <= hi && store_m[i] <= pv) begin bump(); i++; end
				while (j > lo && store_m[j] > pv) begin bump(); j--; end
				if (i >= j) break;
				swap_el(i, j);
			end
			swap_el(lo, j);
			if (j + 1 < hi) begin lo_q.push_back(j + 1); hi_q.push_back(hi); end
			if (lo < j - 1) begin lo_q.push_back(lo); hi_q.push_back(j - 1); end
		end
		for (int k = 0; k < count_m; k++) begin
			o.sorted_value = store_m[k];
			o.end_of_run = (k == count_m - 1);
			o.comparison_count = o.end_of_run ? 16'(cmp_m) : 16'd0;
			sorted_expect.push_back(o);
		end
		count_m = 0;
	endfunction

	function automatic void store_beat(qsps_pkg::in_beat_t b);
		if (count_m < MAXN) begin
			store_m[count_m] = b.value;
			count_m++;
		end
		if (b.last) sort_and_expect();
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_fire) begin
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0 && (quiet || $urandom_range(0, 9) != 0)) begin
				in_data <= pending_beats.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
				if (!quiet && pending_beats.size() > 0) in_gap <= $urandom_range(1, 14);
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				out_gap <= $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				wdog_cnt <= 0;
			else
				wdog_cnt <= wdog_cnt + 1;
			if (in_valid && in_ready)
				store_beat(in_data);
			if (out_valid && out_ready) begin
				if (sorted_expect.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
					errors++;
				end else begin
					qsps_pkg::out_beat_t e;
					e = sorted_expect.pop_front();
					if (out_data.sorted_value !== e.sorted_value) begin
						$display("%0t: sorted_value expected %0d actual %0d", $time,
							e.sorted_value, out_data.sorted_value);
						errors++;
					end
					if (out_data.end_of_run !== e.end_of_run) begin
						$display("%0t: end_of_run expected %0b actual %0b", $time,
							e.end_of_run, out_data.end_of_run);
						errors++;
					end
					if (out_data.comparison_count !== e.comparison_count) begin
						$display("%0t: comparison_count expected %0d actual %0d", $time,
							e.comparison_count, out_data.comparison_count);
						errors++;
					end
				end
			end
			if (wdog_cnt >= WDOG) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == qsps_pkg::REG_PIVOT_MODE) mode_m = val[1:0];
		else lfsr_m = (val == 16'd0) ? 16'd1 : val;
	endtask

	task automatic wait_drained();
		while (pending_beats.size() > 0 || in_valid || sorted_expect.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_value(int kind);
		case (kind)
			0: return $signed($urandom());
			1: return $signed(32'($urandom_range(0, 7)) - 32'sd4);
			default: return ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
		endcase
	endfunction

	task automatic queue_set(int n, int kind);
		qsps_pkg::in_beat_t b;
		for (int k = 0; k < n; k++) begin
			b.value = rand_value(kind);
			b.last = (k == n - 1);
			pending_beats.push_back(b);
		end
	endtask

	initial begin
		qsps_pkg::in_beat_t b;
		int n, phases;
		errors = 0; wdog_cnt = 0; quiet = 0; in_fire = 0; in_gap = 0; out_gap = 0;
		mode_m = qsps_pkg::PIV_FIRST; lfsr_m = 16'd1; count_m = 0; cmp_m = 0;
		in_valid = 0; out_ready = 0; in_data = '0;
		cfg_we = 0; cfg_index = qsps_pkg::REG_PIVOT_MODE; cfg_data = '0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: single element, extremes, ties, all pivot modes
		b.value = 32'sd5; b.last = 1; pending_beats.push_back(b);
		b.value = 32'h7FFFFFFF; b.last = 0; pending_beats.push_back(b);
		b.value = 32'h80000000; pending_beats.push_back(b);
		b.value = 32'hFFFFFFFF; pending_beats.push_back(b);
		b.value = 32'h00000000; b.last = 1; pending_beats.push_back(b);
		wait_drained();
		for (int m = 0; m < 4; m++) begin
			write_reg(qsps_pkg::REG_PIVOT_MODE, 16'(m));
			b.value = 32'sd3; b.last = 0; pending_beats.push_back(b);
			pending_beats.push_back(b);
			b.value = 32'sd1; pending_beats.push_back(b);
			b.value = 32'sd3; b.last = 1; pending_beats.push_back(b);
			wait_drained();
		end
		// overflow: 70 beats, the surplus dropped
		write_reg(qsps_pkg::REG_SEED, 16'd0);
		write_reg(qsps_pkg::REG_PIVOT_MODE, 16'(qsps_pkg::PIV_RANDOM));
		queue_set(70, 0);
		wait_drained();

		phases = 0;
		while (phases < 14) begin
			write_reg(qsps_pkg::REG_PIVOT_MODE, 16'($urandom_range(0, 3)));
			case (phases % 4)
				0: write_reg(qsps_pkg::REG_SEED, 16'hFFFF);
				1: write_reg(qsps_pkg::REG_SEED, 16'd1);
				default: write_reg(qsps_pkg::REG_SEED, 16'($urandom()));
			endcase
			if (phases >= 11) quiet = 1;
			n = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
			queue_set(n, $urandom_range(0, 2));
			wait_drained();
			phases++;
		end

		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
